// ----- sv/wsfh_pkg.sv -----
package wsfh_pkg;

  // field widths
  localparam int CLIENT_W = 8;
  localparam int LEN_W    = 63;
  localparam int BYTE_W   = 8;
  localparam int MAX_RES  = 10;
  localparam int HDR_W    = MAX_RES * BYTE_W;
  localparam int CNT_W    = 4;
  localparam int CFG_IDX_W = 1;

  // default number of client connections
  localparam int NUM_CLIENTS_DEF = 256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENGINE_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 1'd1;

  // per-client fragment state codes
  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_TEXT   = 2'd1;
  localparam logic [1:0] ST_BINARY = 2'd2;

  // frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;

  // extended length markers and limits
  localparam logic [BYTE_W-1:0] LEN16_CODE = 8'd126;
  localparam logic [BYTE_W-1:0] LEN64_CODE = 8'd127;
  localparam logic [LEN_W-1:0]  LEN_SHORT_LIM = 63'd126;
  localparam logic [LEN_W-1:0]  LEN_MID_LIM   = 63'd65536;

  // result counts
  localparam logic [CNT_W-1:0] CNT_ERR   = 4'd1;
  localparam logic [CNT_W-1:0] CNT_SHORT = 4'd2;
  localparam logic [CNT_W-1:0] CNT_MID   = 4'd4;
  localparam logic [CNT_W-1:0] CNT_LONG  = 4'd10;

  // fragment state update toward the state store
  typedef struct packed {
    logic                en;
    logic [CLIENT_W-1:0] client;
    logic [1:0]          state;
  } wsfh_st_wr_t;

  // one built header handed to the serializer
  typedef struct packed {
    logic             err;
    logic [CNT_W-1:0] count;
    logic [HDR_W-1:0] bytes;
  } wsfh_frame_t;

endpackage

// ----- sv/wsfh_state_mem.sv -----
module wsfh_state_mem
  import wsfh_pkg::*;
#(
  parameter int NUM_CLIENTS = NUM_CLIENTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [CLIENT_W-1:0] rd_client,
  input  wsfh_st_wr_t         wr,
  output logic [1:0]          st_out
);

  localparam int SPAN  = 1 << CLIENT_W;
  localparam int DEPTH = (NUM_CLIENTS < SPAN) ? NUM_CLIENTS : SPAN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [1:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [1:0]       rd_data_r;
  logic             rd_vld_r;
  logic             byp_r;
  logic [1:0]       byp_val_r;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             byp_hit;

  assign rd_addr = rd_client[AW-1:0];
  assign wr_addr = wr.client[AW-1:0];
  assign byp_hit = rd_en && wr.en && (wr.client == rd_client);

  // state array with registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.state;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      byp_val_r <= wr.state;
    end
  end

  // valid bits, an entry never written reads as free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
        byp_r    <= byp_hit;
      end
    end
  end

  // a write landing on the same edge as the read wins
  assign st_out = byp_r ? byp_val_r : (rd_vld_r ? rd_data_r : ST_FREE);

`ifndef SYNTHESIS
  a_byp_needs_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(byp_r) |-> $past(rd_en) && $past(wr.en))
    else $error("bypass set without a coinciding read and write");
`endif

endmodule

// ----- sv/wsfh_serializer.sv -----
module wsfh_serializer
  import wsfh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  wsfh_frame_t       frame,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_header_byte,
  output logic              out_last_byte,
  output logic              out_error
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [HDR_W-1:0] sh_r, sh_nxt;
  logic             err_r, err_nxt;
  logic             xfer;

  assign out_valid = (cnt_r != '0);
  assign xfer      = out_valid && out_ready;
  assign free      = (cnt_r == '0) || ((cnt_r == CNT_ERR) && out_ready);

  assign out_header_byte = sh_r[HDR_W-1 -: BYTE_W];
  assign out_last_byte   = (cnt_r == CNT_ERR);
  assign out_error       = err_r;

  // load a whole header or shift one byte out per transfer
  always_comb begin
    cnt_nxt = cnt_r;
    sh_nxt  = sh_r;
    err_nxt = err_r;
    if (load) begin
      cnt_nxt = frame.count;
      sh_nxt  = frame.bytes;
      err_nxt = frame.err;
    end else if (xfer) begin
      cnt_nxt = cnt_r - CNT_ERR;
      sh_nxt  = {sh_r[HDR_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    err_r <= err_nxt;
  end

`ifndef SYNTHESIS
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last_byte)
    else $error("error result is not a single transfer");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cnt_r == $past(frame.count))
    else $error("byte count not taken on load");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("header loaded over bytes still pending");
`endif

endmodule

// ----- sv/websocket_frame_header_builder.sv -----
// Frame header builder: one request on the in_ channel gives the unmasked
// header bytes of one frame on the out_ channel, one byte per transfer in
// wire order, with out_last_byte on the final byte. A rejected request gives
// one transfer with out_error high and out_header_byte zero.
// Bytes per request: 2 for a length under 126, 4 under 65536, 10 otherwise,
// 1 on rejection. The output serializer emits one byte per cycle while
// out_ready is high; back to back requests follow with no gap between
// their bytes. The first byte passes through the input register, then the
// header register in the serializer, before it is valid.
// The input register holds the next request while the current header is
// still being shifted out; in_ready drops only while both are full.
// A receiver stall holds the current byte and stalls the input side.
// Configuration (cfg_index 0 engine enable, 1 max payload) is always ready;
// the user must write it only while no request is in flight; the block does not enforce this.
// Reset (rst_n low, synchronous) disables the engine, sets max payload to
// all ones, empties both stages and marks every client stream free at once.
module websocket_frame_header_builder
  import wsfh_pkg::*;
#(
  parameter int NUM_CLIENTS = NUM_CLIENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic                 in_is_text,
  input  logic                 in_final_fragment,
  input  logic [CLIENT_W-1:0]  in_client,
  input  logic                 in_client_is_websocket,
  input  logic [LEN_W-1:0]     in_payload_length,
  // header byte channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_header_byte,
  output logic                 out_last_byte,
  output logic                 out_error,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  localparam int SPAN = 1 << CLIENT_W;
  localparam logic [CLIENT_W:0] CLIENT_LIM = (NUM_CLIENTS >= SPAN) ?
    (CLIENT_W+1)'(SPAN) : (CLIENT_W+1)'(NUM_CLIENTS);

  logic                engine_enabled_r;
  logic [LEN_W-1:0]    max_payload_r;

  logic                a_valid_r;
  logic                a_action_r;
  logic                a_is_text_r;
  logic                a_fin_r;
  logic [CLIENT_W-1:0] a_client_r;
  logic                a_is_ws_r;
  logic [LEN_W-1:0]    a_len_r;

  logic                in_xfer;
  logic                ser_free;
  logic                ser_load;
  logic [1:0]          st_cur;
  wsfh_st_wr_t         st_wr;
  wsfh_frame_t         frame;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      engine_enabled_r <= 1'b0;
      max_payload_r    <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENGINE_ENABLED: engine_enabled_r <= cfg_data[0];
        CFG_MAX_PAYLOAD:    max_payload_r    <= cfg_data;
        default:            ;
      endcase
    end
  end

  // input register
  assign ser_load = a_valid_r && ser_free;
  assign in_ready = !a_valid_r || ser_free;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_xfer) begin
      a_valid_r <= 1'b1;
    end else if (ser_load) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_action_r  <= in_action;
      a_is_text_r <= in_is_text;
      a_fin_r     <= in_final_fragment;
      a_client_r  <= in_client;
      a_is_ws_r   <= in_client_is_websocket;
      a_len_r     <= in_payload_length;
    end
  end

  // per-client stream state, read as the request enters
  wsfh_state_mem #(
    .NUM_CLIENTS(NUM_CLIENTS)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_xfer),
    .rd_client(in_client),
    .wr       (st_wr),
    .st_out   (st_cur)
  );

  // request checks, state update and header build
  always_comb begin
    logic       in_range;
    logic       len_ok;
    logic [1:0] own;
    logic [1:0] other;
    logic       proto_ok;
    logic       accept_ok;
    logic       cont;
    logic [3:0] opcode;
    logic       fin_bit;
    logic [BYTE_W-1:0] byte0;

    in_range  = ({1'b0, a_client_r} < CLIENT_LIM);
    len_ok    = (a_len_r <= max_payload_r);
    own       = a_is_text_r ? ST_TEXT : ST_BINARY;
    other     = a_is_text_r ? ST_BINARY : ST_TEXT;
    cont      = a_action_r && (st_cur == own);
    opcode    = cont ? OP_CONT : (a_is_text_r ? OP_TEXT : OP_BINARY);
    fin_bit   = a_action_r ? a_fin_r : 1'b1;
    byte0     = {fin_bit, 3'b000, opcode};

    if (a_action_r) begin
      proto_ok = (st_cur != other) && a_is_ws_r;
    end else begin
      proto_ok = (st_cur == ST_FREE) && a_is_ws_r;
    end
    proto_ok  = proto_ok && engine_enabled_r && in_range;
    accept_ok = proto_ok && len_ok;

    // stream fragments move the state even if the size check fails
    st_wr.en     = ser_load && proto_ok && a_action_r;
    st_wr.client = a_client_r;
    st_wr.state  = a_fin_r ? ST_FREE : own;

    frame.err   = !accept_ok;
    frame.count = CNT_ERR;
    frame.bytes = '0;
    if (accept_ok) begin
      if (a_len_r < LEN_SHORT_LIM) begin
        frame.count = CNT_SHORT;
        frame.bytes = {byte0, 1'b0, a_len_r[6:0], {(HDR_W-2*BYTE_W){1'b0}}};
      end else if (a_len_r < LEN_MID_LIM) begin
        frame.count = CNT_MID;
        frame.bytes = {byte0, LEN16_CODE, a_len_r[15:0], {(HDR_W-4*BYTE_W){1'b0}}};
      end else begin
        frame.count = CNT_LONG;
        frame.bytes = {byte0, LEN64_CODE, 1'b0, a_len_r};
      end
    end
  end

  // output serializer
  wsfh_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (ser_load),
    .frame          (frame),
    .free           (ser_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_header_byte(out_header_byte),
    .out_last_byte  (out_last_byte),
    .out_error      (out_error)
  );

`ifndef SYNTHESIS
  a_hold_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !ser_free |-> !in_ready)
    else $error("request taken while the input register is occupied");

  a_state_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.en |-> ser_load && a_action_r && engine_enabled_r)
    else $error("stream state written outside a fragment load");
`endif

endmodule
